### src/ptc_pkg.sv
// shared constants and controller/datapath interface types for the prime tester
package ptc_pkg;

  // width of the candidate number inside the datapath
  localparam int VALUE_BITS = 32;
  // trial divisor width, enough to pass the square root of the largest value
  localparam int DIV_BITS   = VALUE_BITS / 2 + 1;
  // width of the running divisor square
  localparam int SQ_BITS    = 2 * DIV_BITS;
  // index of one bit of the dividend
  localparam int BIT_W      = $clog2(VALUE_BITS);
  // running prime count
  localparam int COUNT_BITS = 32;
  // stream widths
  localparam int IN_BITS    = 32;
  localparam int OUT_BITS   = 40;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;       // capture a new word from the input stream
    logic start_div;  // clear remainder, point at the top dividend bit
    logic step;       // one restoring division step
    logic next_div;   // move on to the next odd divisor
    logic emit;       // write the result register
    logic prime;      // verdict to emit
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic le_one;     // value is 0 or 1
    logic is_two;     // value is 2
    logic is_even;    // low bit clear
    logic past_bound; // divisor squared exceeds value
    logic last_bit;   // division step on the lowest dividend bit
    logic rem_zero;   // remainder of the finished division is zero
    logic out_busy;   // result register still holds an untaken word
  } status_t;

endpackage

### src/ptc_ctrl.sv
// controller state machine sequencing the trial-division test
module ptc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  ptc_pkg::status_t status,
  output ptc_pkg::cmd_t    cmd
);
  import ptc_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CHECK  = 3'd1;
  localparam logic [2:0] ST_DIVIDE = 3'd2;
  localparam logic [2:0] ST_TEST   = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       prime;
  logic       prime_next;

  // state and verdict registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      prime <= 1'b0;
    end else begin
      state <= state_next;
      prime <= prime_next;
    end
  end

  assign s_tready = (state == ST_IDLE);

  // next state and datapath commands
  always_comb begin
    state_next    = state;
    prime_next    = prime;
    cmd           = '0;
    cmd.prime     = prime;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status.le_one) begin
          prime_next = 1'b0;
          state_next = ST_DONE;
        end else if (status.is_two) begin
          prime_next = 1'b1;
          state_next = ST_DONE;
        end else if (status.is_even) begin
          prime_next = 1'b0;
          state_next = ST_DONE;
        end else if (status.past_bound) begin
          prime_next = 1'b1;
          state_next = ST_DONE;
        end else begin
          cmd.start_div = 1'b1;
          state_next    = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        cmd.step = 1'b1;
        if (status.last_bit) begin
          state_next = ST_TEST;
        end
      end
      ST_TEST: begin
        if (status.rem_zero) begin
          prime_next = 1'b0;
          state_next = ST_DONE;
        end else begin
          cmd.next_div = 1'b1;
          state_next   = ST_CHECK;
        end
      end
      ST_DONE: begin
        if (!status.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### src/ptc_datapath.sv
// datapath: candidate, odd divisor and square, bit-serial remainder, count, result
module ptc_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  ptc_pkg::cmd_t                  cmd,
  output ptc_pkg::status_t               status,
  input  logic [ptc_pkg::IN_BITS-1:0]    s_tdata,
  input  logic                           s_tlast,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [ptc_pkg::OUT_BITS-1:0]   m_tdata,
  output logic                           m_tlast
);
  import ptc_pkg::*;

  logic [VALUE_BITS-1:0] num;
  logic                  last;
  logic [DIV_BITS-1:0]   div;
  logic [SQ_BITS-1:0]    sq;
  logic [DIV_BITS-1:0]   rem;
  logic [BIT_W-1:0]      bit_idx;
  logic [COUNT_BITS-1:0] count;
  logic [COUNT_BITS-1:0] count_next;
  logic                  out_valid;
  logic                  out_prime;
  logic [COUNT_BITS-1:0] out_count;
  logic                  out_last;
  logic [DIV_BITS:0]     trial;
  logic [DIV_BITS:0]     trial_sub;

  // restoring division step: bring down one dividend bit
  assign trial     = {rem, num[bit_idx]};
  assign trial_sub = trial - {1'b0, div};

  // candidate, divisor and square
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      num  <= VALUE_BITS'(s_tdata);
      last <= s_tlast;
      div  <= DIV_BITS'(3);
      sq   <= SQ_BITS'(9);
    end else if (cmd.next_div) begin
      // (d + 2)^2 = d^2 + 4d + 4
      div  <= div + DIV_BITS'(2);
      sq   <= sq + (SQ_BITS'(div) << 2) + SQ_BITS'(4);
    end
  end

  // remainder and bit pointer
  always_ff @(posedge clk) begin
    if (cmd.start_div) begin
      rem     <= '0;
      bit_idx <= BIT_W'(VALUE_BITS - 1);
    end else if (cmd.step) begin
      rem     <= trial_sub[DIV_BITS] ? trial[DIV_BITS-1:0] : trial_sub[DIV_BITS-1:0];
      bit_idx <= bit_idx - BIT_W'(1);
    end
  end

  // running count of primes in the open range
  assign count_next = count + COUNT_BITS'(cmd.prime);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.emit) begin
      count <= last ? '0 : count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_prime <= cmd.prime;
      out_count <= count_next;
      out_last  <= last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = OUT_BITS'({out_count, out_prime});
  assign m_tlast  = out_last;

  // status flags
  always_comb begin
    status.le_one     = (num <= VALUE_BITS'(1));
    status.is_two     = (num == VALUE_BITS'(2));
    status.is_even    = ~num[0];
    status.past_bound = (sq > SQ_BITS'(num));
    status.last_bit   = (bit_idx == '0);
    status.rem_zero   = (rem == '0);
    status.out_busy   = out_valid & ~m_tready;
  end

endmodule

### src/prime_test_and_count.sv
// top level of the trial-division prime tester with running prime count
//
// Input stream: one word per candidate; s_tdata carries the number, s_tlast
// marks the last number of a counted range. Output stream: one word per
// input word, in order; m_tdata carries the verdict and the count of primes
// in the range so far including this word, m_tlast echoes the range mark
// and the count starts again from zero after such a word.
// No divisor is tried for 0, 1, even numbers and odd numbers below 9; the
// verdict is settled by the checks alone. Each odd divisor tried takes
// a bound check, 32 division steps and a remainder test. Divisors
// 3, 5, 7, ... are tried while d*d <= n; a prime runs through all of them,
// a composite stops at the divisor that hits. The remainder is formed
// one dividend bit per cycle by a single restoring subtractor. The next
// word can be taken in the cycle after the result is written.
// One number is in work at a time; s_tready is high only while idle, and
// a new word may be taken while the previous result still waits in the
// output register. If the receiver stalls, a finished result waits in the
// controller until that register is free.
// Reset (rst, synchronous) empties the output register, clears the count
// and returns the controller to idle.
module prime_test_and_count (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [ptc_pkg::IN_BITS-1:0]  s_tdata,  // [31:0] value
  input  logic                         s_tlast,  // last_in_range
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [ptc_pkg::OUT_BITS-1:0] m_tdata,  // [0] is_prime, [32:1] prime_count
  output logic                         m_tlast   // range_done
);
  import ptc_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencing
  ptc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // arithmetic and result register
  ptc_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

### test/prime_tally_checker.sv
// stream monitor that predicts prime verdicts and range counts and compares them
module prime_tally_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  input  logic                         s_tready,
  input  logic [ptc_pkg::IN_BITS-1:0]  s_tdata,   // [31:0] value
  input  logic                         s_tlast,   // last_in_range
  input  logic                         m_tvalid,
  input  logic                         m_tready,
  input  logic [ptc_pkg::OUT_BITS-1:0] m_tdata,   // [0] is_prime, [32:1] prime_count
  input  logic                         m_tlast,   // range_done
  output int                           fail_count,
  output int                           outstanding
);

  typedef struct packed {
    logic                           is_prime;
    logic [ptc_pkg::COUNT_BITS-1:0] prime_count;
    logic                           range_done;
  } verdict_t;

  // verdicts still owed by the block, oldest first
  verdict_t verdict_q[$];
  // primes seen in the open range
  logic [ptc_pkg::COUNT_BITS-1:0] range_primes = '0;

  // trial division by odd divisors while d*d <= n, bound kept as d <= n/d
  function automatic logic odd_trial_prime(input logic [ptc_pkg::IN_BITS-1:0] n);
    logic [ptc_pkg::IN_BITS-1:0] d;
    if (n <= 1) return 1'b0;
    if (n == 2) return 1'b1;
    if (n[0] == 1'b0) return 1'b0;
    for (d = 3; d <= n / d; d += 2)
      if (n % d == 0) return 1'b0;
    return 1'b1;
  endfunction

  // watch both channels; the outgoing word is always older than the incoming one
  always @(posedge clk) begin : watch
    verdict_t want;
    logic     verdict;
    if (rst) begin
      range_primes = '0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (verdict_q.size() == 0) begin
          $error("result word with no candidate outstanding: m_tdata=%h m_tlast=%b",
                 m_tdata, m_tlast);
          fail_count++;
        end else begin
          want = verdict_q.pop_front();
          if (m_tdata[0] !== want.is_prime) begin
            $error("is_prime: expected %0d, got %0d", want.is_prime, m_tdata[0]);
            fail_count++;
          end
          if (m_tdata[ptc_pkg::COUNT_BITS:1] !== want.prime_count) begin
            $error("prime_count: expected %0d, got %0d", want.prime_count,
                   m_tdata[ptc_pkg::COUNT_BITS:1]);
            fail_count++;
          end
          if (m_tlast !== want.range_done) begin
            $error("range_done: expected %0d, got %0d", want.range_done, m_tlast);
            fail_count++;
          end
        end
      end
      // predict the verdict for an accepted candidate
      if (s_tvalid && s_tready) begin
        verdict = odd_trial_prime(s_tdata);
        if (verdict) range_primes = range_primes + 1'b1;
        want.is_prime    = verdict;
        want.prime_count = range_primes;
        want.range_done  = s_tlast;
        verdict_q.push_back(want);
        if (s_tlast) range_primes = '0;
      end
      outstanding = verdict_q.size();
    end
  end

endmodule

### test/tb_top.sv
// top of the prime tester bench: clock, reset, candidate stimulus and verdict
module tb_top;

  logic                         clk;
  logic                         rst;
  logic                         s_tvalid;
  logic                         s_tready;
  logic [ptc_pkg::IN_BITS-1:0]  s_tdata;   // [31:0] value
  logic                         s_tlast;   // last_in_range
  logic                         m_tvalid;
  logic                         m_tready = 1'b0;
  logic [ptc_pkg::OUT_BITS-1:0] m_tdata;   // [0] is_prime, [32:1] prime_count
  logic                         m_tlast;   // range_done

  int fail_count;
  int outstanding;
  int burst_left;
  int tick = 0;
  int rdy_mode = 0;

  prime_test_and_count i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  prime_tally_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // receiver stall pattern, picking a new random mode whenever the low six bits of tick are zero
  always @(posedge clk) begin
    tick <= tick + 1;
    if (tick[5:0] == 6'd0) rdy_mode <= $urandom_range(0, 3);
    case (rdy_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= tick[2];
      2: m_tready <= ($urandom_range(0, 3) != 0);
      default: m_tready <= (tick[5:4] == 2'b11);
    endcase
  end

  // offer one candidate word, with bursts separated by random gaps
  task automatic send_candidate(input logic [31:0] value, input logic last);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 24 : $urandom_range(1, 6);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    burst_left--;
  endtask

  // candidate stimulus and final verdict
  initial begin : stimulus
    logic [31:0] corner_values [21];
    logic [20:0] corner_lasts;
    logic [31:0] value;
    int          i;
    corner_values = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd9, 32'd25, 32'd49,
                      32'd63001, 32'd7919, 32'd65521, 32'd65535, 32'd16777213,
                      32'hFFFFFFFF, 32'hFFFFFFFE, 32'h80000000, 32'h55555555,
                      32'hAAAAAAAA, 32'd97, 32'd7};
    // ranges close on a composite, on a prime, twice in a row, and at the end
    corner_lasts = 21'b1_0110_0000_0100_0001_0000;
    s_tvalid   <= 1'b0;
    s_tdata    <= '0;
    s_tlast    <= 1'b0;
    rst        <= 1'b1;
    burst_left = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed corners: trivial values, squares of primes, wide values
    for (i = 0; i < 21; i++)
      send_candidate(corner_values[i], corner_lasts[i]);

    // random candidates, mostly small so primes stay cheap to test
    for (i = 0; i < 79; i++) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: value = $urandom_range(0, 4095);
        12, 13, 14: value = $urandom_range(4096, 32'h0010_0000);
        15, 16, 17: begin
          value = $urandom;
          value = value - value % 3;
        end
        default: value = $urandom & 32'hFFFF_FFFE;
      endcase
      send_candidate(value, $urandom_range(0, 9) == 0);
    end
    s_tvalid <= 1'b0;

    // drain outstanding verdicts, then a short settling tail
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  // watchdog
  initial begin
    #200000000;
    $display("FAILURE");
    $finish;
  end

endmodule

### files.f
src/ptc_pkg.sv
src/ptc_ctrl.sv
src/ptc_datapath.sv
src/prime_test_and_count.sv
test/prime_tally_checker.sv
test/tb_top.sv
